>>> rtl/core/pssq_pkg.sv
`timescale 1ns / 1ps

package pssq_pkg;

  localparam int unsigned NUM_SLICES_DEF = 8;
  localparam int unsigned STEP_W         = 32;
  localparam int unsigned COUNT_W        = 4;
  localparam int unsigned INDEX_W        = 3;

  // next_step value when no slice offers a later step
  localparam logic signed [STEP_W-1:0] STEP_NONE_NEXT = 32'sh7fff_ffff;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_t;

  // one table entry as stored in the slice memory
  typedef struct packed {
    logic signed [STEP_W-1:0] start;
    logic signed [STEP_W-1:0] stop;
    logic signed [STEP_W-1:0] period;
  } slice_t;

endpackage

>>> rtl/core/pssq_ram.sv
`timescale 1ns / 1ps

module pssq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pssq_div.sv
`timescale 1ns / 1ps

// Restoring divider, remainder only, one quotient bit per cycle.
module pssq_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [pssq_pkg::STEP_W-1:0] dividend,
  input  logic [pssq_pkg::STEP_W-1:0] divisor,
  output logic                     done,
  output logic [pssq_pkg::STEP_W-1:0] remainder
);

  import pssq_pkg::*;

  localparam int unsigned CNT_W = $clog2(STEP_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [STEP_W-1:0] rem_r;
  logic [STEP_W-1:0] rem_nxt;
  logic [STEP_W-1:0] dvd_r;
  logic [STEP_W-1:0] dsr_r;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;

  always_comb begin
    trial = {rem_r, dvd_r[STEP_W-1]};
    diff  = trial - {1'b0, dsr_r};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = diff[STEP_W-1:0];
    end else begin
      rem_nxt = trial[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEP_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[STEP_W-2:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> rtl/core/periodic_slice_schedule_query.sv
`timescale 1ns / 1ps

// Periodic slice schedule query. A table of up to NUM_SLICES slices (start,
// stop, period) sits in one synchronous RAM. A write word (operation 0)
// stores one entry and gives no result; an index at or beyond NUM_SLICES
// is dropped. A query word (operation 1) walks the first slice_count
// entries (saturated to NUM_SLICES) one at a time: read the entry, run two
// remainder dividers side by side (one for the step itself, one for the
// last candidate at or below the step), then fold the slice into the
// running next/previous/contained result. A slice with a period of zero or
// below skips the dividers. One query is in flight at a time: in_stall
// stays high until it is finished, so table reads never overlap table
// writes. The result sits in an output register, and a new word is taken
// while it waits for the consumer. slice_count is written through the cfg
// port, which is always ready; write it only while no query is running.
module periodic_slice_schedule_query #(
  parameter int unsigned NUM_SLICES = pssq_pkg::NUM_SLICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input word channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic [pssq_pkg::INDEX_W-1:0]       in_slice_index,
  input  logic signed [pssq_pkg::STEP_W-1:0] in_slice_start,
  input  logic signed [pssq_pkg::STEP_W-1:0] in_slice_stop,
  input  logic signed [pssq_pkg::STEP_W-1:0] in_slice_period,
  input  logic signed [pssq_pkg::STEP_W-1:0] in_step,
  // result word channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_in_schedule,
  output logic signed [pssq_pkg::STEP_W-1:0] out_next_step,
  output logic signed [pssq_pkg::STEP_W-1:0] out_previous_step,
  output logic signed [pssq_pkg::STEP_W-1:0] out_previous_inclusive,
  output logic signed [pssq_pkg::STEP_W-1:0] out_local_period,
  output logic                               out_activated,
  // slice_count register
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pssq_pkg::COUNT_W-1:0]       cfg_slice_count
);

  import pssq_pkg::*;

  localparam int unsigned ADDR_W = (NUM_SLICES > 1) ? $clog2(NUM_SLICES) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_SLICES + 1);
  localparam int unsigned IDX_EXT_W = 7;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] slice_count_r;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   cnt_r;
  logic               last_slice;

  logic signed [STEP_W-1:0] n_r;
  logic                     hit_r;
  logic                     act_r;
  logic signed [STEP_W-1:0] next_r;
  logic signed [STEP_W-1:0] prev_r;
  logic                     ge_r;
  logic                     mge_r;
  logic signed [STEP_W-1:0] m_r;

  // handshake / control
  logic accept;
  logic start_query;
  logic rd_en;
  logic div_start;
  logic slice_adv;
  logic out_load;

  // table memory
  logic                 tbl_we;
  logic [IDX_EXT_W-1:0] idx_ext;
  slice_t               wr_ent;
  slice_t               ent;

  // per-slice arithmetic
  logic                   per_ok;
  logic signed [STEP_W:0] s33, e33, n33, n_m1, m33, d1_33, d2_33;
  logic                   ge, mge;
  logic                   div_done_a, div_done_b;
  logic [STEP_W-1:0]      rem_a, rem_b;
  logic signed [STEP_W+1:0] next_cand;
  logic signed [STEP_W-1:0] prev_cand;
  logic                     take_next, take_prev, slice_hit;

  logic signed [STEP_W-1:0] incl;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      slice_count_r <= cfg_slice_count;
    end
  end

  // entries that take part, saturated at the table depth
  always_comb begin
    if (32'(slice_count_r) > NUM_SLICES) begin
      used = CNT_W'(NUM_SLICES);
    end else begin
      used = CNT_W'(slice_count_r);
    end
  end

  assign last_slice = ({1'b0, cnt_r} + 1'b1) == {1'b0, used};

  // ---------------------------------------------------------------------
  // slice table
  // ---------------------------------------------------------------------
  assign accept      = in_valid && !in_stall;
  assign start_query = accept && (in_operation == OP_QUERY);
  assign idx_ext     = IDX_EXT_W'(in_slice_index);
  assign tbl_we      = accept && (in_operation == OP_WRITE) &&
                       (32'(in_slice_index) < NUM_SLICES);
  assign wr_ent      = '{start: in_slice_start, stop: in_slice_stop,
                         period: in_slice_period};

  pssq_ram #(
    .WIDTH ($bits(slice_t)),
    .DEPTH (NUM_SLICES)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (idx_ext[ADDR_W-1:0]),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (cnt_r[ADDR_W-1:0]),
    .rdata (ent)
  );

  // ---------------------------------------------------------------------
  // entry decode (valid in ST_LOAD, RAM output holds until the next read)
  // ---------------------------------------------------------------------
  always_comb begin
    per_ok = !ent.period[STEP_W-1] && (ent.period != '0);
    s33    = {ent.start[STEP_W-1], ent.start};
    e33    = {ent.stop[STEP_W-1], ent.stop};
    n33    = {n_r[STEP_W-1], n_r};
    n_m1   = n33 - 33'sd1;
    // last candidate at or below the step: min(step - 1, stop)
    m33    = (e33 < n_m1) ? e33 : n_m1;
    ge     = n33 >= s33;
    mge    = m33 >= s33;
    d1_33  = n33 - s33;
    d2_33  = m33 - s33;
  end

  // d1 = step - start, d2 = m - start; only remainders are needed
  pssq_div u_div_next (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (d1_33[STEP_W-1:0]),
    .divisor   (ent.period),
    .done      (div_done_a),
    .remainder (rem_a)
  );

  pssq_div u_div_prev (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (d2_33[STEP_W-1:0]),
    .divisor   (ent.period),
    .done      (div_done_b),
    .remainder (rem_b)
  );

  // ---------------------------------------------------------------------
  // fold one slice into the running result (ST_ACC)
  // next = step - r1 + period (start when step < start), prev = m - r2
  // ---------------------------------------------------------------------
  always_comb begin
    if (ge_r) begin
      next_cand = {{2{n_r[STEP_W-1]}}, n_r} - {2'b00, rem_a} +
                  {{2{ent.period[STEP_W-1]}}, ent.period};
    end else begin
      next_cand = {{2{ent.start[STEP_W-1]}}, ent.start};
    end
    prev_cand = m_r - $signed(rem_b);
    take_next = (next_cand <= $signed({{2{ent.stop[STEP_W-1]}}, ent.stop})) &&
                (next_cand < $signed({{2{next_r[STEP_W-1]}}, next_r}));
    take_prev = mge_r && (prev_cand > prev_r);
    slice_hit = ge_r && (n_r <= ent.stop) && (rem_a == '0);
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_query) begin
          state_nxt = (used == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (per_ok) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = last_slice ? ST_DONE : ST_READ;
        end
      end
      ST_DIV: begin
        if (div_done_a) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = last_slice ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    rd_en     = (state_r == ST_READ);
    div_start = (state_r == ST_LOAD) && per_ok;
    slice_adv = (state_r == ST_ACC) || ((state_r == ST_LOAD) && !per_ok);
    out_load  = (state_r == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      hit_r   <= 1'b0;
      act_r   <= 1'b0;
      next_r  <= STEP_NONE_NEXT;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_query) begin
        cnt_r  <= '0;
        hit_r  <= 1'b0;
        act_r  <= 1'b0;
        next_r <= STEP_NONE_NEXT;
        prev_r <= '0;
      end else begin
        if (slice_adv) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if ((state_r == ST_LOAD) && per_ok && (ent.stop >= ent.start)) begin
          act_r <= 1'b1;
        end
        if (state_r == ST_ACC) begin
          if (slice_hit) begin
            hit_r <= 1'b1;
          end
          if (take_next) begin
            next_r <= next_cand[STEP_W-1:0];
          end
          if (take_prev) begin
            prev_r <= prev_cand;
          end
        end
      end
    end
  end

  // query step and per-slice operands; no reset needed
  always_ff @(posedge clk) begin
    if (start_query) begin
      n_r <= in_step;
    end
    if (state_r == ST_LOAD) begin
      ge_r  <= ge;
      mge_r <= mge;
      m_r   <= m33[STEP_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  assign incl = hit_r ? n_r : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_in_schedule        <= hit_r;
      out_next_step          <= next_r;
      out_previous_step      <= prev_r;
      out_previous_inclusive <= incl;
      out_local_period       <= next_r - incl;
      out_activated          <= act_r;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_a == div_done_b)
    else $error("divider pair out of step");

  a_prev_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !prev_r[STEP_W-1])
    else $error("previous step went negative");

  a_next_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |=> (next_r <= $past(next_r)))
    else $error("next step grew during a query");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (cnt_r < used))
    else $error("slice walk ran past the used count");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (state_r == ST_IDLE) && !rd_en)
    else $error("table write during a query");

endmodule
